// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the k-way merge RTL.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define KWM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define KWM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/kwm_pkg.sv =====
// Constants, types and helper functions of the k-way merge block.
// Depends on nothing; used by every other file but assert_macros.svh.
package kwm_pkg;

  localparam int LISTS       = 4;
  localparam int LIST_DEPTH  = 16;
  localparam int VALUE_WIDTH = 32;

  localparam int DATA_W     = 32;
  localparam int IDX_W      = 2;
  localparam int STORE_SIZE = LISTS * LIST_DEPTH;
  localparam int LIST_W     = $clog2(LISTS);
  localparam int SCAN_W     = $clog2(LISTS + 1);
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
  localparam int ADDR_W     = $clog2(STORE_SIZE);
  localparam int TOT_W      = $clog2(STORE_SIZE + 1);

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_MERGE = 1'b1;

  typedef logic [LIST_W-1:0]      list_t;
  typedef logic [SCAN_W-1:0]      scan_t;
  typedef logic [CNT_W-1:0]       cnt_t;
  typedef logic [ADDR_W-1:0]      addr_t;
  typedef logic [TOT_W-1:0]       tot_t;
  typedef logic [VALUE_WIDTH-1:0] val_t;

  // Sequencer to minimum unit
  typedef struct packed {
    logic  clear;
    logic  sample;
    list_t list;
  } min_ctl_t;

  // Minimum unit back to sequencer
  typedef struct packed {
    logic  found;
    list_t list;
    val_t  val;
  } min_res_t;

  function automatic addr_t addr_of(list_t l, cnt_t p);
    return ADDR_W'(int'(l) * LIST_DEPTH + int'(p));
  endfunction

  // Keep the low bits of the raw beat value, zero-extended if the store is wider.
  function automatic val_t to_store(logic [DATA_W-1:0] v);
    return VALUE_WIDTH'(v);
  endfunction

  // Sign-extend from the stored width, then keep the port width.
  function automatic logic [DATA_W-1:0] to_out(val_t v);
    return DATA_W'($signed(v));
  endfunction

endpackage

// ===== rtl/kwm_in_if.sv =====
// Input channel of the k-way merge block: valid/ready plus the load/merge beat.
// Depends on kwm_pkg.
interface kwm_in_if;
  logic                                valid;
  logic                                ready;
  logic                                mode;
  logic [kwm_pkg::IDX_W-1:0]           list_index;
  logic signed [kwm_pkg::DATA_W-1:0]   value;

  modport source (output valid, output mode, output list_index, output value, input ready);
  modport sink   (input valid, input mode, input list_index, input value, output ready);
endinterface

// ===== rtl/kwm_out_if.sv =====
// Output channel of the k-way merge block: valid/ready plus one merged result.
// Depends on kwm_pkg.
interface kwm_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [kwm_pkg::DATA_W-1:0]   value_res;
  logic                                last;
  logic                                empty_set;
  logic                                dropped;

  modport source (output valid, output value_res, output last, output empty_set,
                  output dropped, input ready);
  modport sink   (input valid, input value_res, input last, input empty_set,
                  input dropped, output ready);
endinterface

// ===== rtl/kwm_store.sv =====
// Element store: one write port, one read port with registered read data.
// Depends on kwm_pkg.
module kwm_store (
  input  logic           clk_i,
  input  logic           wr_en_i,
  input  kwm_pkg::addr_t wr_addr_i,
  input  kwm_pkg::val_t  wr_data_i,
  input  logic           rd_en_i,
  input  kwm_pkg::addr_t rd_addr_i,
  output kwm_pkg::val_t  rd_data_o
);

  kwm_pkg::val_t mem [kwm_pkg::STORE_SIZE];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

// ===== rtl/kwm_min_unit.sv =====
// Shared compare unit: keeps the smallest head seen during one scan.
// Depends on kwm_pkg.
module kwm_min_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  kwm_pkg::min_ctl_t ctl_i,
  input  kwm_pkg::val_t     data_i,
  output kwm_pkg::min_res_t res_o
);

  logic          found_q;
  kwm_pkg::list_t list_q;
  kwm_pkg::val_t  val_q;
  logic          take;

  // Strictly smaller only, so on a tie the lower list number stays.
  assign take = ctl_i.sample && (!found_q || ($signed(data_i) < $signed(val_q)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (ctl_i.clear) begin
      found_q <= 1'b0;
    end else if (take) begin
      found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && !ctl_i.clear) begin
      list_q <= ctl_i.list;
      val_q  <= data_i;
    end
  end

  assign res_o.found = found_q;
  assign res_o.list  = list_q;
  assign res_o.val   = val_q;

endmodule

// ===== rtl/k_way_sorted_merge.sv =====
// K-way merge of sorted lists: top level with the merge sequencer.
// Depends on kwm_pkg, kwm_in_if, kwm_out_if, kwm_store, kwm_min_unit, assert_macros.svh.
//
// Usage
//   in_i carries beats of mode, list_index and value. A load beat (mode 0) appends
//   value to the named list; a full list drops it and sets the sticky
//   dropped flag. A merge beat (mode 1) emits every stored value on out_o in
//   non-decreasing signed order, last set on the final beat, dropped on all of
//   them. With nothing loaded a merge gives one beat with empty_set set and value 0.
//   The lists and the flag are cleared once the final beat is registered.
// Timing
//   Loads: one per cycle, ready stays high while idle.
//   Merge: each result takes one store read per list that still holds values, through
//   the single read port and the shared compare unit, then the winner is registered
//   into the output register. in_i is not ready during a merge.
// Reset and stall
//   Reset empties all lists and the output register; the store needs no clearing.
//   A stalled out_o holds its beat and the sequencer waits with the next winner.
`include "assert_macros.svh"

module k_way_sorted_merge (
  input  logic      clk_i,
  input  logic      rst_ni,
  kwm_in_if.sink    in_i,
  kwm_out_if.source out_o
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_EMIT  = 2'd2;
  localparam logic [1:0] S_EMPTY = 2'd3;

  logic [1:0]        state_q, state_d;
  kwm_pkg::cnt_t     fill_q   [kwm_pkg::LISTS];
  kwm_pkg::cnt_t     fill_d   [kwm_pkg::LISTS];
  kwm_pkg::cnt_t     rd_pos_q [kwm_pkg::LISTS];
  kwm_pkg::cnt_t     rd_pos_d [kwm_pkg::LISTS];
  logic              dropped_q, dropped_d;
  kwm_pkg::tot_t     remaining_q, remaining_d, total;
  kwm_pkg::scan_t    scan_q, scan_d;
  logic              rd_vld_q;
  kwm_pkg::list_t    rd_list_q;
  logic [kwm_pkg::LISTS-1:0] avail;

  logic              in_acc, out_free, idx_ok, sel_full, last_res;
  kwm_pkg::list_t    wl, sl;

  logic              wr_en, rd_en;
  kwm_pkg::addr_t    wr_addr, rd_addr;
  kwm_pkg::val_t     wr_data, rd_data;

  kwm_pkg::min_ctl_t min_ctl;
  kwm_pkg::min_res_t min_res;

  logic                        out_vld_q, out_load;
  logic [kwm_pkg::DATA_W-1:0]  out_val_q, out_val_d;
  logic                        out_last_q, out_last_d;
  logic                        out_empty_q, out_empty_d;
  logic                        out_drop_q;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_free   = !out_vld_q || out_o.ready;
  assign idx_ok     = 32'(in_i.list_index) < 32'(kwm_pkg::LISTS);
  assign wl         = kwm_pkg::LIST_W'(in_i.list_index);
  assign sel_full   = fill_q[wl] == kwm_pkg::CNT_W'(kwm_pkg::LIST_DEPTH);
  assign sl         = scan_q[kwm_pkg::LIST_W-1:0];
  assign last_res   = remaining_q == kwm_pkg::TOT_W'(1);
  assign wr_addr    = kwm_pkg::addr_of(wl, fill_q[wl]);
  assign wr_data    = kwm_pkg::to_store(in_i.value);
  assign rd_addr    = kwm_pkg::addr_of(sl, rd_pos_q[sl]);

  always_comb begin
    for (int l = 0; l < kwm_pkg::LISTS; l++) begin
      avail[l] = rd_pos_q[l] < fill_q[l];
    end
  end

  always_comb begin
    total = '0;
    for (int l = 0; l < kwm_pkg::LISTS; l++) begin
      total = total + kwm_pkg::TOT_W'(fill_q[l]);
    end
  end

  always_comb begin
    state_d        = state_q;
    fill_d         = fill_q;
    rd_pos_d       = rd_pos_q;
    dropped_d      = dropped_q;
    remaining_d    = remaining_q;
    scan_d         = scan_q;
    wr_en          = 1'b0;
    rd_en          = 1'b0;
    min_ctl.clear  = 1'b0;
    min_ctl.sample = rd_vld_q;
    min_ctl.list   = rd_list_q;
    out_load       = 1'b0;
    out_val_d      = kwm_pkg::to_out(min_res.val);
    out_last_d     = 1'b0;
    out_empty_d    = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (in_i.mode == kwm_pkg::MODE_LOAD) begin
            if (idx_ok) begin
              if (sel_full) begin
                dropped_d = 1'b1;
              end else begin
                wr_en      = 1'b1;
                fill_d[wl] = fill_q[wl] + kwm_pkg::CNT_W'(1);
              end
            end
          end else begin
            remaining_d = total;
            if (total == '0) begin
              state_d = S_EMPTY;
            end else begin
              state_d       = S_SCAN;
              scan_d        = '0;
              min_ctl.clear = 1'b1;
            end
          end
        end
      end
      S_SCAN: begin
        // Issue one head read per list that still holds values; the compare runs in the cycle after each read.
        if (scan_q != kwm_pkg::SCAN_W'(kwm_pkg::LISTS)) begin
          rd_en  = avail[sl];
          scan_d = scan_q + kwm_pkg::SCAN_W'(1);
        end else begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_load    = 1'b1;
          out_last_d  = last_res;
          remaining_d = remaining_q - kwm_pkg::TOT_W'(1);
          for (int l = 0; l < kwm_pkg::LISTS; l++) begin
            if (kwm_pkg::LIST_W'(l) == min_res.list) begin
              rd_pos_d[l] = rd_pos_q[l] + kwm_pkg::CNT_W'(1);
            end
          end
          if (last_res) begin
            for (int l = 0; l < kwm_pkg::LISTS; l++) begin
              fill_d[l]   = '0;
              rd_pos_d[l] = '0;
            end
            dropped_d = 1'b0;
            state_d   = S_IDLE;
          end else begin
            state_d       = S_SCAN;
            scan_d        = '0;
            min_ctl.clear = 1'b1;
          end
        end
      end
      S_EMPTY: begin
        if (out_free) begin
          out_load    = 1'b1;
          out_val_d   = '0;
          out_last_d  = 1'b1;
          out_empty_d = 1'b1;
          for (int l = 0; l < kwm_pkg::LISTS; l++) begin
            fill_d[l]   = '0;
            rd_pos_d[l] = '0;
          end
          dropped_d = 1'b0;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      dropped_q   <= 1'b0;
      remaining_q <= '0;
      scan_q      <= '0;
      rd_vld_q    <= 1'b0;
      out_vld_q   <= 1'b0;
      for (int l = 0; l < kwm_pkg::LISTS; l++) begin
        fill_q[l]   <= '0;
        rd_pos_q[l] <= '0;
      end
    end else begin
      state_q     <= state_d;
      dropped_q   <= dropped_d;
      remaining_q <= remaining_d;
      scan_q      <= scan_d;
      rd_vld_q    <= rd_en;
      fill_q      <= fill_d;
      rd_pos_q    <= rd_pos_d;
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_list_q <= sl;
    if (out_load) begin
      out_val_q   <= out_val_d;
      out_last_q  <= out_last_d;
      out_empty_q <= out_empty_d;
      out_drop_q  <= dropped_q;
    end
  end

  assign out_o.valid     = out_vld_q;
  assign out_o.value_res = out_val_q;
  assign out_o.last      = out_last_q;
  assign out_o.empty_set = out_empty_q;
  assign out_o.dropped   = out_drop_q;

  kwm_store u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  kwm_min_unit u_min (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (min_ctl),
    .data_i (rd_data),
    .res_o  (min_res)
  );

  `KWM_ASSERT_IMP(a_emit_has_min, state_q == S_EMIT, min_res.found, "emit without a head")
  `KWM_ASSERT_IMP(a_run_not_done, (state_q == S_SCAN) || (state_q == S_EMIT),
                  remaining_q != '0, "merge run with no values left")
  `KWM_ASSERT_IMP(a_read_in_scan, rd_vld_q, state_q == S_SCAN, "store read outside scan")
  `KWM_ASSERT_NXT(a_clear_at_end, (state_q == S_EMIT) && out_free && last_res,
                  (state_q == S_IDLE) && !dropped_q && (total == '0),
                  "lists not cleared after final beat")

endmodule
